### design/tpo_pkg.sv
// Shared constants and types for the triangle ownership block.
// No dependencies; used by triangle_primitive_ownership_top.
package tpo_pkg;

  localparam int IDX_W   = 12;             // vertex index width
  localparam int KEY_W   = 2 * IDX_W;      // edge key {smaller, larger}
  localparam int EPOCH_W = 8;              // mesh generation tag width
  localparam int HASH_W  = 32;

  localparam logic [HASH_W-1:0] HASH_MUL = 32'd2654435761;

  typedef logic [EPOCH_W-1:0] epoch_t;
  typedef logic [KEY_W-1:0]   key_t;

  typedef struct packed {
    logic overflow;
    logic own_bc;
    logic own_ac;
    logic own_ab;
    logic own_c;
    logic own_b;
    logic own_a;
  } result_t;

endpackage

### design/triangle_primitive_ownership_top.sv
// Triangle ownership tracker: vertex tag memory, hashed edge memory, control FSM.
// Depends on tpo_pkg.
//
// One triangle is handled at a time. Each vertex is read, then checked and written back
// in the vertex tag memory; an index beyond the bitmap skips the check. Each edge forms
// its key and hash, then reads and checks the linearly probed edge memory, one slot per
// probe. After the last edge the result is handed off, and the block returns to idle
// before the next item is accepted.
// Entries carry a mesh generation tag, so new_mesh costs nothing until the tag
// wraps: after reset, and on every 255th new_mesh, a clearing pass sweeps both
// memories while s_tready is low.
module triangle_primitive_ownership_top #(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_EDGES    = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // corner_a, corner_b, corner_c, 4'b0
  input  logic        s_tuser,   // new_mesh
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // own_a, own_b, own_c, own_ab, own_ac, own_bc,
                                 // edge_store_overflow, 1'b0
);

  localparam int VA_W  = $clog2(MAX_VERTICES);
  localparam int EA_W  = $clog2(MAX_EDGES);
  localparam int EC_W  = $clog2(MAX_EDGES + 1);
  localparam int CLR_N = (MAX_VERTICES > MAX_EDGES) ? MAX_VERTICES : MAX_EDGES;
  localparam int CW    = $clog2(CLR_N);
  localparam int PW    = tpo_pkg::HASH_W + EC_W;
  localparam int EW    = tpo_pkg::EPOCH_W + tpo_pkg::KEY_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLR  = 4'd1;
  localparam logic [3:0] ST_VRD  = 4'd2;
  localparam logic [3:0] ST_VCHK = 4'd3;
  localparam logic [3:0] ST_EH1  = 4'd4;
  localparam logic [3:0] ST_EH2  = 4'd5;
  localparam logic [3:0] ST_ERD  = 4'd6;
  localparam logic [3:0] ST_ECHK = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0] state;
  logic [CW-1:0] clr_cnt;
  logic [tpo_pkg::IDX_W-1:0] va, vb, vc;
  logic [1:0] sel;
  tpo_pkg::epoch_t epoch;
  tpo_pkg::result_t res;
  logic overflow;
  logic [EC_W-1:0] edge_count;
  logic [EC_W-1:0] probes;
  logic [EA_W-1:0] slot;
  logic [tpo_pkg::HASH_W-1:0] hash;
  tpo_pkg::key_t key;

  tpo_pkg::epoch_t vmem [MAX_VERTICES];
  logic [EW-1:0]   emem [MAX_EDGES];
  tpo_pkg::epoch_t v_rdata;
  logic [EW-1:0]   e_rdata;

  logic                  v_we, e_we;
  logic [VA_W-1:0]       v_waddr;
  tpo_pkg::epoch_t       v_wdata;
  logic [EA_W-1:0]       e_waddr;
  logic [EW-1:0]         e_wdata;
  logic [EA_W-1:0]       e_raddr;

  logic [tpo_pkg::IDX_W-1:0] cur_v, ep, eq, lo, hi;
  logic [16:0]               cur_v_ext;
  logic                      v_in_range;
  logic [VA_W-1:0]           v_addr;
  logic [55:0]               hmul;
  logic [PW-1:0]             smul;
  logic                      e_valid, e_match, v_new;
  logic [EC_W-1:0]           slot_inc;

  always_comb begin
    unique case (sel)
      2'd0:    cur_v = va;
      2'd1:    cur_v = vb;
      default: cur_v = vc;
    endcase
    unique case (sel)
      2'd0:    begin ep = va; eq = vb; end
      2'd1:    begin ep = va; eq = vc; end
      default: begin ep = vb; eq = vc; end
    endcase
    cur_v_ext  = 17'(cur_v);
    v_in_range = cur_v_ext < 17'(MAX_VERTICES);
    v_addr     = cur_v_ext[VA_W-1:0];
    lo         = (ep < eq) ? ep : eq;
    hi         = (ep < eq) ? eq : ep;
    hmul       = 56'(key) * 56'(tpo_pkg::HASH_MUL);
    smul       = PW'(hash) * PW'(MAX_EDGES);
    v_new      = (v_rdata != epoch);
    e_valid    = (e_rdata[EW-1 -: tpo_pkg::EPOCH_W] == epoch);
    e_match    = (e_rdata[tpo_pkg::KEY_W-1:0] == key);
    slot_inc   = EC_W'(slot) + EC_W'(1);
    // first probe reads the home slot straight from the hash
    e_raddr    = (state == ST_ERD && probes == '1) ? smul[tpo_pkg::HASH_W +: EA_W] : slot;
  end

  // memory write ports
  always_comb begin
    v_we    = 1'b0;
    v_waddr = v_addr;
    v_wdata = epoch;
    e_we    = 1'b0;
    e_waddr = slot;
    e_wdata = {epoch, key};
    if (state == ST_CLR) begin
      v_we    = 32'(clr_cnt) < MAX_VERTICES;
      v_waddr = clr_cnt[VA_W-1:0];
      v_wdata = '0;
      e_we    = 32'(clr_cnt) < MAX_EDGES;
      e_waddr = clr_cnt[EA_W-1:0];
      e_wdata = '0;
    end else if (state == ST_VCHK) begin
      v_we = v_new;
    end else if (state == ST_ECHK) begin
      e_we = !e_valid && (edge_count < EC_W'(MAX_EDGES));
    end
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    if (e_we) begin
      emem[e_waddr] <= e_wdata;
    end
    v_rdata <= vmem[v_addr];
    e_rdata <= emem[e_raddr];
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      clr_cnt    <= '0;
      epoch      <= '0;
      overflow   <= 1'b0;
      edge_count <= '0;
      m_tvalid   <= 1'b0;
      sel        <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            va  <= s_tdata[11:0];
            vb  <= s_tdata[23:12];
            vc  <= s_tdata[35:24];
            sel <= '0;
            res <= '0;
            if (s_tuser) begin
              edge_count <= '0;
              if (epoch == '1) begin
                clr_cnt <= '0;
                state   <= ST_CLR;
              end else begin
                epoch <= epoch + tpo_pkg::EPOCH_W'(1);
                state <= ST_VRD;
              end
            end else begin
              state <= ST_VRD;
            end
          end
        end
        ST_CLR: begin
          clr_cnt <= clr_cnt + CW'(1);
          if (32'(clr_cnt) == CLR_N - 1) begin
            epoch <= tpo_pkg::EPOCH_W'(1);
            // after reset go idle; after a tag wrap continue the triangle
            state <= (epoch == '0) ? ST_IDLE : ST_VRD;
          end
        end
        ST_VRD: begin
          if (v_in_range) begin
            state <= ST_VCHK;
          end else if (sel == 2'd2) begin
            sel   <= '0;
            state <= ST_EH1;
          end else begin
            sel <= sel + 2'd1;
          end
        end
        ST_VCHK: begin
          unique case (sel)
            2'd0:    res.own_a <= v_new;
            2'd1:    res.own_b <= v_new;
            default: res.own_c <= v_new;
          endcase
          if (sel == 2'd2) begin
            sel   <= '0;
            state <= ST_EH1;
          end else begin
            sel   <= sel + 2'd1;
            state <= ST_VRD;
          end
        end
        ST_EH1: begin
          key   <= {lo, hi};
          state <= ST_EH2;
        end
        ST_EH2: begin
          hash   <= hmul[tpo_pkg::HASH_W-1:0];
          probes <= '1;
          state  <= ST_ERD;
        end
        ST_ERD: begin
          if (probes == '1) begin
            probes <= '0;
          end
          state <= ST_ECHK;
        end
        ST_ECHK: begin
          if (!e_valid || e_match || probes == EC_W'(MAX_EDGES - 1)) begin
            if (!e_valid && edge_count < EC_W'(MAX_EDGES)) begin
              edge_count <= edge_count + EC_W'(1);
              unique case (sel)
                2'd0:    res.own_ab <= 1'b1;
                2'd1:    res.own_ac <= 1'b1;
                default: res.own_bc <= 1'b1;
              endcase
            end else if (!e_match || !e_valid) begin
              overflow <= 1'b1;
            end
            if (sel == 2'd2) begin
              state <= ST_OUT;
            end else begin
              sel   <= sel + 2'd1;
              state <= ST_EH1;
            end
          end else begin
            probes <= probes + EC_W'(1);
            state  <= ST_ERD;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // slot: loaded from the hash, advanced on a probe miss
  always_ff @(posedge clk) begin
    if (state == ST_EH2) begin
      slot <= '0;
    end else if (state == ST_ERD && probes == '1) begin
      slot <= smul[tpo_pkg::HASH_W +: EA_W];
    end else if (state == ST_ECHK && e_valid && !e_match) begin
      slot <= (slot_inc == EC_W'(MAX_EDGES)) ? '0 : slot_inc[EA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, overflow, res.own_bc, res.own_ac, res.own_ab,
                  res.own_c, res.own_b, res.own_a};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    edge_count <= EC_W'(MAX_EDGES))
    else $error("edge count beyond capacity");
  a_out_from_fsm: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_OUT))
    else $error("result raised outside hand-off state");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLR |-> !s_tready)
    else $error("item accepted during clearing pass");
  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_VCHK || state == ST_ECHK) |-> epoch != '0)
    else $error("lookup with cleared generation tag");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for triangle_primitive_ownership_top: directed rows, random triangles
// under several idle mixes, and a run of wide random triangles with mostly distinct edges.
// Depends on tpo_pkg and the RTL of the block; reads no files.
module testbench;

  localparam int NUM_VERTS = 4096;
  localparam int EDGE_CAP  = 8192;

  typedef logic [tpo_pkg::IDX_W-1:0] idx_t;

  typedef struct {
    idx_t              a, b, c;
    logic              nm;
    logic              typed;
    tpo_pkg::result_t  claim;
  } row_t;

  logic        clk, rst;
  logic        s_tvalid, s_tready, s_tuser;
  logic [39:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [7:0]  m_tdata;

  // model state
  bit          vert_owned [NUM_VERTS];
  bit          edge_owned [tpo_pkg::key_t];
  bit          ovf_sticky;

  tpo_pkg::result_t claims_due [$];
  int          send_idle_pct, recv_stall_pct;
  int          mismatches = 0;

  triangle_primitive_ownership_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic claim_vert(idx_t v);
    if (vert_owned[v]) return 1'b0;
    vert_owned[v] = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic claim_edge(idx_t p, idx_t q);
    tpo_pkg::key_t k;
    k = (p < q) ? {p, q} : {q, p};
    if (edge_owned.exists(k)) return 1'b0;
    if (edge_owned.num() >= EDGE_CAP) begin
      ovf_sticky = 1'b1;
      return 1'b0;
    end
    edge_owned[k] = 1'b1;
    return 1'b1;
  endfunction

  function automatic tpo_pkg::result_t predict_claims(idx_t a, idx_t b, idx_t c, logic nm);
    tpo_pkg::result_t r;
    if (nm) begin
      foreach (vert_owned[i]) vert_owned[i] = 1'b0;
      edge_owned.delete();
    end
    r.own_a    = claim_vert(a);
    r.own_b    = claim_vert(b);
    r.own_c    = claim_vert(c);
    r.own_ab   = claim_edge(a, b);
    r.own_ac   = claim_edge(a, c);
    r.own_bc   = claim_edge(b, c);
    r.overflow = ovf_sticky;
    return r;
  endfunction

  // Present one triangle; a typed claim replaces the predicted one in the queue.
  task automatic send_tri(idx_t a, idx_t b, idx_t c,
                          logic nm, logic typed = 1'b0, tpo_pkg::result_t claim = '0);
    int gap;
    tpo_pkg::result_t r;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, c, b, a};
    s_tuser  <= nm;
    do @(posedge clk); while (!s_tready);
    r = predict_claims(a, b, c, nm);
    claims_due.push_back(typed ? claim : r);
  endtask

  // Receiver: random stall, compare every accepted result with the oldest claim.
  always @(posedge clk) begin
    tpo_pkg::result_t got, want;
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      got = tpo_pkg::result_t'(m_tdata[6:0]);
      if (claims_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %b", m_tdata);
      end else begin
        want = claims_due.pop_front();
        if (got.own_a !== want.own_a || got.own_b !== want.own_b ||
            got.own_c !== want.own_c || got.own_ab !== want.own_ab ||
            got.own_ac !== want.own_ac || got.own_bc !== want.own_bc ||
            got.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("claim mismatch: expected %b actual %b", want, got);
        end
      end
    end
  end

  // drop the last item so it is not taken twice, then wait for all results
  task automatic drain;
    s_tvalid <= 1'b0;
    while (claims_due.size() != 0) @(posedge clk);
  endtask

  task automatic random_tri(logic nm_ok);
    idx_t a, b, c;
    logic nm;
    if ($urandom_range(3) == 0) begin
      a = idx_t'($urandom); b = idx_t'($urandom); c = idx_t'($urandom);
    end else begin
      // small pool so vertices and edges get shared
      a = idx_t'($urandom_range(47));
      b = idx_t'($urandom_range(47));
      c = idx_t'($urandom_range(47));
    end
    if ($urandom_range(9) == 0) b = a;
    if ($urandom_range(14) == 0) c = b;
    nm = nm_ok && ($urandom_range(39) == 0);
    send_tri(a, b, c, nm);
  endtask

  row_t directed [$];

  initial begin
    idx_t fa, fb, fc;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    ovf_sticky = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    //               a      b      c      nm  typed  claim {ovf,bc,ac,ab,c,b,a}
    directed.push_back('{12'd0,    12'd4095, 12'd2048, 1'b0, 1'b1, 7'b0111111});
    directed.push_back('{12'd0,    12'd4095, 12'd2048, 1'b0, 1'b1, 7'b0000000});
    directed.push_back('{12'd4095, 12'd2048, 12'd0,    1'b0, 1'b1, 7'b0000000});
    directed.push_back('{12'd5,    12'd5,    12'd5,    1'b0, 1'b1, 7'b0001001});
    directed.push_back('{12'd5,    12'd5,    12'd5,    1'b0, 1'b1, 7'b0000000});
    directed.push_back('{12'd0,    12'd4095, 12'd2048, 1'b1, 1'b1, 7'b0111111});
    directed.push_back('{12'd4095, 12'd4095, 12'd7,    1'b0, 1'b1, 7'b0011100});
    directed.push_back('{12'd7,    12'd7,    12'd4095, 1'b0, 1'b1, 7'b0001000});
    directed.push_back('{12'hAAA,  12'h555,  12'hAAA,  1'b0, 1'b0, '0});
    directed.push_back('{12'h555,  12'hAAA,  12'h123,  1'b0, 1'b0, '0});
    directed.push_back('{12'hFFE,  12'h001,  12'h800,  1'b0, 1'b0, '0});
    directed.push_back('{12'h001,  12'h002,  12'h003,  1'b1, 1'b0, '0});
    directed.push_back('{12'h003,  12'h002,  12'h001,  1'b0, 1'b0, '0});
    directed.push_back('{12'h002,  12'h004,  12'h002,  1'b0, 1'b0, '0});
    directed.push_back('{12'h7FF,  12'h800,  12'h7FF,  1'b1, 1'b0, '0});
    foreach (directed[i])
      send_tri(directed[i].a, directed[i].b, directed[i].c, directed[i].nm,
               directed[i].typed, directed[i].claim);
    drain();

    // idle mixes: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 77 : (ph == 3) ? 10 : 0;
      recv_stall_pct = (ph == 2) ? 77 : (ph == 3) ? 10 : 0;
      repeat (190) random_tri(1'b1);
    end

    // wide random triangles: mostly distinct edges, longer probe chains
    send_idle_pct = 0; recv_stall_pct = 0;
    fa = 12'd1; fb = 12'd2; fc = 12'd3;
    send_tri(fa, fb, fc, 1'b1);
    repeat (45) send_tri(idx_t'($urandom), idx_t'($urandom), idx_t'($urandom), 1'b0);
    send_idle_pct = 10; recv_stall_pct = 10;
    send_tri(fb, fa, fc, 1'b0);         // stored edges still recognized
    send_tri(12'd4000, 12'd4001, fa, 1'b0);
    send_tri(fa, fb, fc, 1'b1);         // new mesh after a long run
    repeat (20) random_tri(1'b1);

    drain();
    repeat (200) @(posedge clk);
    s_tvalid <= 1'b0;
    if (mismatches == 0 && claims_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### triangle_primitive_ownership_top.f
design/tpo_pkg.sv
design/triangle_primitive_ownership_top.sv
tb/testbench.sv
